// ===== hdl/integer_grid_text_parser_assert.svh =====
// assertion macros for the integer grid text parser checker
// expects clk and rst_n in the scope where the macros are used
`ifndef INTEGER_GRID_TEXT_PARSER_ASSERT_SVH
`define INTEGER_GRID_TEXT_PARSER_ASSERT_SVH

// same-cycle implication
`define IGTP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("igtp assertion failed");

// next-cycle implication
`define IGTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("igtp assertion failed");

`endif

// ===== hdl/igtp_pkg.sv =====
// shared types, constants and helpers for the integer grid text parser
// no dependencies
package igtp_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLUMNS = 1024;
    localparam int COUNT_W     = $clog2(((MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS) + 1);
    localparam int COORD_W     = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_ILLEGAL    = 3'd1;
    localparam status_t ST_LONE_MINUS = 3'd2;
    localparam status_t ST_WIDTH      = 3'd3;
    localparam status_t ST_OVERFLOW   = 3'd4;

    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_MINUS,
        TK_SPACE,
        TK_NEWLINE,
        TK_ILLEGAL,
        TK_END
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  digit;
    } token_t;

    typedef struct packed {
        logic   valid;
        token_t token;
    } tok_chan_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_t;

    typedef struct packed {
        logic signed [31:0]   value;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   column;
        logic                 row_end;
        status_t              status;
        logic                 done_res;
    } result_t;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [COUNT_W-1:0] x);
        logic [COUNT_W-1:0] lim;
        lim = COUNT_W'((1 << COORD_W) - 1);
        return (x > lim) ? {COORD_W{1'b1}} : x[COORD_W-1:0];
    endfunction

endpackage

// ===== hdl/igtp_front.sv =====
// front end: classifies each text request into a token and pushes it into the queue
// depends on igtp_pkg
module igtp_front (
    input  logic              text_valid,
    input  igtp_pkg::text_t   text,
    output logic              text_stall,
    input  logic              queue_full,
    output igtp_pkg::tok_chan_t push
);
    import igtp_pkg::*;

    token_t tok;

    always_comb
    begin
        tok.digit = text.text_byte[3:0];
        if (text.end_of_text)
        begin
            tok.kind = TK_END;
        end
        else
        begin
            case (text.text_byte) inside
                [CH_ZERO:CH_NINE]: tok.kind = TK_DIGIT;
                CH_MINUS:          tok.kind = TK_MINUS;
                CH_SPACE:          tok.kind = TK_SPACE;
                CH_NEWLINE:        tok.kind = TK_NEWLINE;
                default:           tok.kind = TK_ILLEGAL;
            endcase
        end
    end

    assign text_stall = queue_full;
    assign push.valid = text_valid && !queue_full;
    assign push.token = tok;

endmodule

// ===== hdl/igtp_queue.sv =====
// short token queue between front and back end
// depends on igtp_pkg
module igtp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  igtp_pkg::tok_chan_t push,
    output logic                full,
    output igtp_pkg::tok_chan_t head,
    input  logic                pop
);
    import igtp_pkg::*;

    token_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.token = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/igtp_back.sv =====
// back end: parser state, number accumulation, grid checks and result register
// depends on igtp_pkg
module igtp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  igtp_pkg::tok_chan_t head,
    output logic                pop,
    output logic                result_valid,
    output igtp_pkg::result_t   result,
    input  logic                result_stall
);
    import igtp_pkg::*;

    logic [31:0]        acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               in_num_reg, in_num_next;
    logic               pminus_reg, pminus_next;
    logic [COUNT_W-1:0] col_reg, col_next;
    logic [COUNT_W-1:0] row_reg, row_next;
    logic [COUNT_W-1:0] ref_reg, ref_next;
    logic               wk_reg, wk_next;
    status_t            err_reg, err_next;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;

    logic               take, emit, ends_row;
    logic               do_fail, do_finish, do_close;
    status_t            fail_code, fin_code;
    logic [COUNT_W-1:0] col_inc, close_col;
    logic [31:0]        acc_x10;
    result_t            r;

    assign take     = head.valid && (!res_valid_reg || !result_stall);
    assign pop      = take;
    assign ends_row = (head.token.kind == TK_NEWLINE) || (head.token.kind == TK_END);
    assign col_inc  = col_reg + 1'b1;
    assign acc_x10  = (acc_reg << 3) + (acc_reg << 1);

    always_comb
    begin
        if (col_reg >= COUNT_W'(MAX_COLUMNS) || row_reg >= COUNT_W'(MAX_ROWS))
        begin
            fin_code = ST_OVERFLOW;
        end
        else if (wk_reg && col_reg >= ref_reg)
        begin
            fin_code = ST_WIDTH;
        end
        else if (ends_row && wk_reg && col_inc != ref_reg)
        begin
            fin_code = ST_WIDTH;
        end
        else
        begin
            fin_code = ST_OK;
        end
    end

    // token decode
    always_comb
    begin
        do_fail   = 1'b0;
        do_finish = 1'b0;
        do_close  = 1'b0;
        fail_code = ST_OK;
        if (take && err_reg == ST_OK)
        begin
            case (head.token.kind)
                TK_DIGIT:
                begin
                end
                TK_MINUS:
                begin
                    if (in_num_reg)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ST_ILLEGAL;
                    end
                    else if (pminus_reg)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ST_LONE_MINUS;
                    end
                end
                TK_SPACE, TK_NEWLINE, TK_END:
                begin
                    if (pminus_reg)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ST_LONE_MINUS;
                    end
                    else if (in_num_reg)
                    begin
                        if (fin_code != ST_OK)
                        begin
                            do_fail   = 1'b1;
                            fail_code = fin_code;
                        end
                        else
                        begin
                            do_finish = 1'b1;
                            do_close  = ends_row;
                        end
                    end
                    else if (ends_row && col_reg != '0)
                    begin
                        if (wk_reg && col_reg != ref_reg)
                        begin
                            do_fail   = 1'b1;
                            fail_code = ST_WIDTH;
                        end
                        else
                        begin
                            do_close = 1'b1;
                        end
                    end
                end
                default:
                begin
                    do_fail   = 1'b1;
                    fail_code = ST_ILLEGAL;
                end
            endcase
        end
    end

    // state update and result build
    always_comb
    begin
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        in_num_next = in_num_reg;
        pminus_next = pminus_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        ref_next    = ref_reg;
        wk_next     = wk_reg;
        err_next    = err_reg;
        emit        = 1'b0;
        r           = '0;
        close_col   = do_finish ? col_inc : col_reg;

        if (take && err_reg == ST_OK)
        begin
            if (head.token.kind == TK_DIGIT)
            begin
                if (in_num_reg)
                begin
                    acc_next = acc_x10 + 32'(head.token.digit);
                end
                else
                begin
                    neg_next    = pminus_reg;
                    pminus_next = 1'b0;
                    in_num_next = 1'b1;
                    acc_next    = 32'(head.token.digit);
                end
            end
            else if (head.token.kind == TK_MINUS && !do_fail)
            begin
                pminus_next = 1'b1;
            end
        end

        if (do_fail)
        begin
            emit     = 1'b1;
            err_next = fail_code;
            r.status = fail_code;
            r.row    = sat_coord(row_reg);
            r.column = sat_coord(col_reg);
        end

        if (do_finish)
        begin
            emit        = 1'b1;
            r.value     = neg_reg ? (32'd0 - acc_reg) : acc_reg;
            r.row       = sat_coord(row_reg);
            r.column    = sat_coord(col_reg);
            r.row_end   = ends_row;
            col_next    = col_inc;
            in_num_next = 1'b0;
            neg_next    = 1'b0;
            acc_next    = '0;
        end

        if (do_close)
        begin
            if (!wk_reg)
            begin
                ref_next = close_col;
                wk_next  = 1'b1;
            end
            if (row_reg < COUNT_W'(MAX_ROWS))
            begin
                row_next = row_reg + 1'b1;
            end
            col_next = '0;
        end

        if (take && head.token.kind == TK_END)
        begin
            emit       = 1'b1;
            r.done_res = 1'b1;
            if (err_reg != ST_OK)
            begin
                r.status = err_reg;
            end
            acc_next    = '0;
            neg_next    = 1'b0;
            in_num_next = 1'b0;
            pminus_next = 1'b0;
            col_next    = '0;
            row_next    = '0;
            ref_next    = '0;
            wk_next     = 1'b0;
            err_next    = ST_OK;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (take && emit)
        begin
            res_valid_next = 1'b1;
            res_next       = r;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            in_num_reg    <= 1'b0;
            pminus_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            ref_reg       <= '0;
            wk_reg        <= 1'b0;
            err_reg       <= ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            in_num_reg    <= in_num_next;
            pminus_reg    <= pminus_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            ref_reg       <= ref_next;
            wk_reg        <= wk_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== hdl/integer_grid_text_parser.sv =====
// top level of the integer grid text parser: front end, token queue, back end
// depends on igtp_pkg, igtp_front, igtp_queue, igtp_back
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------------
//   text     | text_valid / text_stall     | text_byte, end_of_text
//   result   | result_valid / result_stall | value, row, column, row_end, status,
//            |                             | done_res
//
// one request per cycle unless stalled; a token is queued, then its result registered
// the per-cycle limit is the back end's accumulate-times-ten and grid compares
// a two-entry token queue separates the front end from the back end
// text_stall rises only when the queue is full, i.e. result_stall held back the back end
// rst_n clears parser state, queue and result valid flag at once; no clearing pass
module integer_grid_text_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_valid,
    input  igtp_pkg::text_t   text,
    output logic              text_stall,
    output logic              result_valid,
    output igtp_pkg::result_t result,
    input  logic              result_stall
);
    import igtp_pkg::*;

    tok_chan_t push, head;
    logic      queue_full, pop;

    igtp_front u_front (
        .text_valid (text_valid),
        .text       (text),
        .text_stall (text_stall),
        .queue_full (queue_full),
        .push       (push)
    );

    igtp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    igtp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule

// ===== hdl/igtp_checker.sv =====
// port-level checks for the integer grid text parser, bound to the top level
// depends on igtp_pkg and integer_grid_text_parser_assert.svh
`include "integer_grid_text_parser_assert.svh"

module igtp_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_valid,
    input  igtp_pkg::text_t   text,
    input  logic              text_stall,
    input  logic              result_valid,
    input  igtp_pkg::result_t result,
    input  logic              result_stall
);
    import igtp_pkg::*;

    logic err_taken;

    assign err_taken = result_valid && !result_stall && (result.status != ST_OK)
                       && !result.done_res;

    `IGTP_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
    `IGTP_ASSERT_NOW(a_error_shape, result_valid && (result.status != ST_OK), (result.value == 0) && !result.row_end)
    `IGTP_ASSERT_NEXT(a_error_sticky, err_taken, !result_valid || result.done_res)

endmodule

bind integer_grid_text_parser igtp_checker u_igtp_checker (.*);

// ===== dv/tb_top.sv =====
// self-checking testbench for the integer grid text parser
// holds its own parse predictor and drives grids, faults and noise with random idling
// depends on igtp_pkg and integer_grid_text_parser
module tb_top;
    import igtp_pkg::*;

    localparam int unsigned COORD_MAX = (1 << COORD_W) - 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;
    localparam int TOTAL_ITEMS = 1400;

    logic clk;
    logic rst_n;
    logic text_valid;
    text_t text;
    logic text_stall;
    logic result_valid;
    result_t result;
    logic result_stall;

    // predictor state
    logic [31:0] acc;
    bit neg;
    bit in_num;
    bit pend_minus;
    int unsigned col_cnt;
    int unsigned row_idx;
    int unsigned ref_width;
    bit width_known;
    status_t err_code;

    result_t predicted_numbers[$];
    result_t oldest;

    int send_gap_max;
    int recv_wait_max;
    int hold_len;
    int mismatches;
    int accepted_items;
    int live_items;
    int checked_results;
    int status_seen[0:7];
    int idle_cycles;

    integer_grid_text_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text         (text),
        .text_stall   (text_stall),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_parse_state();
        acc = '0;
        neg = 1'b0;
        in_num = 1'b0;
        pend_minus = 1'b0;
        col_cnt = 0;
        row_idx = 0;
        ref_width = 0;
        width_known = 1'b0;
        err_code = ST_OK;
    endfunction

    function automatic result_t make_result(input logic [31:0] value, input int unsigned row,
                                            input int unsigned col, input bit row_end,
                                            input status_t status, input bit done);
        result_t r;
        r.value = value;
        r.row = (row > COORD_MAX) ? COORD_W'(COORD_MAX) : COORD_W'(row);
        r.column = (col > COORD_MAX) ? COORD_W'(COORD_MAX) : COORD_W'(col);
        r.row_end = row_end;
        r.status = status;
        r.done_res = done;
        return r;
    endfunction

    function automatic result_t raise_error(input status_t code, input bit done);
        err_code = code;
        return make_result('0, row_idx, col_cnt, 1'b0, code, done);
    endfunction

    function automatic void close_row();
        if (!width_known)
        begin
            ref_width = col_cnt;
            width_known = 1'b1;
        end
        if (row_idx < MAX_ROWS)
            row_idx++;
        col_cnt = 0;
    endfunction

    function automatic result_t finish_number(input bit ends_row, input bit done);
        result_t r;
        logic [31:0] v;
        if (col_cnt >= MAX_COLUMNS || row_idx >= MAX_ROWS)
            return raise_error(ST_OVERFLOW, done);
        if (width_known && col_cnt >= ref_width)
            return raise_error(ST_WIDTH, done);
        if (ends_row && width_known && col_cnt + 1 != ref_width)
            return raise_error(ST_WIDTH, done);
        v = neg ? (32'd0 - acc) : acc;
        r = make_result(v, row_idx, col_cnt, ends_row, ST_OK, done);
        col_cnt++;
        in_num = 1'b0;
        neg = 1'b0;
        acc = '0;
        if (ends_row)
            close_row();
        return r;
    endfunction

    // returns 1 when the byte produces a result
    function automatic bit parse_byte(input logic [7:0] ch, input bit last, output result_t res);
        res = '0;
        if (last)
        begin
            if (err_code != ST_OK)
                res = make_result('0, 0, 0, 1'b0, err_code, 1'b1);
            else if (pend_minus)
                res = raise_error(ST_LONE_MINUS, 1'b1);
            else if (in_num)
                res = finish_number(1'b1, 1'b1);
            else if (col_cnt > 0 && width_known && col_cnt != ref_width)
                res = raise_error(ST_WIDTH, 1'b1);
            else
                res = make_result('0, 0, 0, 1'b0, ST_OK, 1'b1);
            clear_parse_state();
            return 1'b1;
        end
        if (err_code != ST_OK)
            return 1'b0;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            if (in_num)
                acc = acc * 32'd10 + 32'(ch - CH_ZERO);
            else
            begin
                neg = pend_minus;
                pend_minus = 1'b0;
                in_num = 1'b1;
                acc = 32'(ch - CH_ZERO);
            end
            return 1'b0;
        end
        if (ch == CH_MINUS)
        begin
            if (in_num)
            begin
                res = raise_error(ST_ILLEGAL, 1'b0);
                return 1'b1;
            end
            if (pend_minus)
            begin
                res = raise_error(ST_LONE_MINUS, 1'b0);
                return 1'b1;
            end
            pend_minus = 1'b1;
            return 1'b0;
        end
        if (ch == CH_SPACE)
        begin
            if (pend_minus)
            begin
                res = raise_error(ST_LONE_MINUS, 1'b0);
                return 1'b1;
            end
            if (in_num)
            begin
                res = finish_number(1'b0, 1'b0);
                return 1'b1;
            end
            return 1'b0;
        end
        if (ch == CH_NEWLINE)
        begin
            if (pend_minus)
            begin
                res = raise_error(ST_LONE_MINUS, 1'b0);
                return 1'b1;
            end
            if (in_num)
            begin
                res = finish_number(1'b1, 1'b0);
                return 1'b1;
            end
            if (col_cnt > 0)
            begin
                if (width_known && col_cnt != ref_width)
                begin
                    res = raise_error(ST_WIDTH, 1'b0);
                    return 1'b1;
                end
                close_row();
            end
            return 1'b0;
        end
        res = raise_error(ST_ILLEGAL, 1'b0);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch %0d: %s got %0h expected %0h", mismatches, what, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_numbers.size() == 0)
                report_mismatch("unexpected result, value", result.value, '0);
            else
            begin
                oldest = predicted_numbers.pop_front();
                checked_results++;
                status_seen[oldest.status]++;
                if (result.value !== oldest.value)
                    report_mismatch("value", result.value, oldest.value);
                if (result.row !== oldest.row)
                    report_mismatch("row", 32'(result.row), 32'(oldest.row));
                if (result.column !== oldest.column)
                    report_mismatch("column", 32'(result.column), 32'(oldest.column));
                if (result.row_end !== oldest.row_end)
                    report_mismatch("row_end", 32'(result.row_end), 32'(oldest.row_end));
                if (result.status !== oldest.status)
                    report_mismatch("status", 32'(result.status), 32'(oldest.status));
                if (result.done_res !== oldest.done_res)
                    report_mismatch("done_res", 32'(result.done_res), 32'(oldest.done_res));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_valid && !text_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("integer_grid_text_parser verification failed");
                $finish;
            end
        end
    end

    // result receiver with random stalls and requested hold-offs
    initial
    begin
        int n;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_len > 0)
            begin
                n = hold_len;
                hold_len = 0;
            end
            else
                n = (recv_wait_max > 0) ? $urandom_range(0, recv_wait_max) : 0;
            @(negedge clk);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    task automatic send_char(input logic [7:0] ch, input bit last);
        int gap;
        text_t req;
        result_t res;
        gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
        req.text_byte = ch;
        req.end_of_text = last;
        @(negedge clk);
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_valid <= 1'b1;
        text <= req;
        do @(posedge clk); while (text_stall);
        accepted_items++;
        if (err_code == ST_OK)
            live_items++;
        if (parse_byte(ch, last, res))
            predicted_numbers.push_back(res);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        text_valid <= 1'b0;
        while (predicted_numbers.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_idle();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 2;
            2: return 6;
            default: return 18;
        endcase
    endfunction

    function automatic logic [7:0] illegal_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0, 1: return 8'h61 + 8'($urandom_range(0, 25));
            2: return 8'h0D;
            3: return 8'h00;
            default:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SPACE || b == CH_NEWLINE
                       || b == CH_MINUS);
                return b;
            end
        endcase
    endfunction

    task automatic send_number(input bit allow_minus);
        int len;
        if (allow_minus && $urandom_range(0, 2) == 0)
            send_char(CH_MINUS, 1'b0);
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: send_text("2147483647");
                    1: send_text("2147483648");
                    2: send_text("4294967295");
                    3: send_text("4294967296");
                    default: send_text("0000000000");
                endcase
                len = 0;
            end
            1: len = $urandom_range(5, 12);
            default: len = $urandom_range(1, 4);
        endcase
        repeat (len) send_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    // fault: 0 none, 1 illegal byte, 2 minus in number, 3 double minus,
    // 4 lone minus, 5 extra number in a row, 6 missing number in a row
    task automatic send_grid(input int fault);
        int n_cols;
        int n_rows;
        int fault_row;
        int fault_col;
        int cols_here;
        n_cols = $urandom_range(1, 5);
        n_rows = $urandom_range(1, 5);
        if (fault >= 5 && n_rows < 2)
            n_rows = 2;
        if (fault == 6 && n_cols < 2)
            n_cols = 2;
        fault_row = (fault >= 5) ? $urandom_range(1, n_rows - 1) : $urandom_range(0, n_rows - 1);
        fault_col = $urandom_range(0, n_cols - 1);
        for (int r = 0; r < n_rows; r++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                if ($urandom_range(0, 1))
                    send_text("\n");
                else
                    send_text("  \n");
            end
            if ($urandom_range(0, 4) == 0)
                send_char(CH_SPACE, 1'b0);
            cols_here = n_cols;
            if (r == fault_row && fault == 5)
                cols_here++;
            if (r == fault_row && fault == 6)
                cols_here--;
            for (int c = 0; c < cols_here; c++)
            begin
                if (c > 0)
                    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1)
                        send_char(CH_SPACE, 1'b0);
                if (r == fault_row && c == fault_col && fault >= 1 && fault <= 4)
                begin
                    case (fault)
                        1:
                        begin
                            send_char(illegal_byte(), 1'b0);
                            send_number(1'b1);
                        end
                        2:
                        begin
                            send_number(1'b0);
                            send_char(CH_MINUS, 1'b0);
                            send_number(1'b0);
                        end
                        3:
                        begin
                            send_text("--");
                            send_number(1'b0);
                        end
                        default: send_char(CH_MINUS, 1'b0);
                    endcase
                end
                else
                    send_number(1'b1);
            end
            if ($urandom_range(0, 4) == 0)
                send_char(CH_SPACE, 1'b0);
            if (r < n_rows - 1 || $urandom_range(0, 1))
                send_char(CH_NEWLINE, 1'b0);
        end
        send_end();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 4))
                0: send_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                1: send_char(CH_SPACE, 1'b0);
                2: send_char(CH_NEWLINE, 1'b0);
                3: send_char(CH_MINUS, 1'b0);
                default: send_char(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        send_end();
    endtask

    task automatic test_directed_cases();
        send_gap_max = 3;
        recv_wait_max = 3;
        // minus zero, empty line, trailing space before newline
        send_text("9 -0\n\n1 2 \n");
        send_end();
        send_text("5-");
        send_end();
        send_text("- ");
        send_end();
        send_char(8'hFF, 1'b0);
        send_end();
        // number flushed by end of text
        send_text("7");
        send_end();
        wait_drained();
    endtask

    task automatic test_result_backpressure();
        send_gap_max = 0;
        recv_wait_max = 0;
        hold_len = 300;
        repeat (40) send_text("12 ");
        send_end();
        wait_drained();
    endtask

    task automatic test_sender_pause();
        send_gap_max = 2;
        recv_wait_max = 18;
        repeat (4)
        begin
            send_text("3 -4\n");
            wait_drained();
        end
        send_end();
        wait_drained();
    endtask

    task automatic test_random_grids();
        int pick;
        while (accepted_items < TOTAL_ITEMS)
        begin
            send_gap_max = pick_idle();
            recv_wait_max = pick_idle();
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_grid(0);
            else if (pick < 9)
                send_grid($urandom_range(1, 6));
            else
                send_noise();
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        text_valid = 1'b0;
        text = '0;
        send_gap_max = 0;
        recv_wait_max = 0;
        hold_len = 0;
        mismatches = 0;
        accepted_items = 0;
        live_items = 0;
        checked_results = 0;
        idle_cycles = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        clear_parse_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_result_backpressure();
        test_sender_pause();
        test_random_grids();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("sent %0d bytes (%0d parsed before an error), checked %0d results",
                 accepted_items, live_items, checked_results);
        $display("results by status: ok %0d, illegal %0d, lone minus %0d, width %0d, overflow %0d",
                 status_seen[ST_OK], status_seen[ST_ILLEGAL], status_seen[ST_LONE_MINUS],
                 status_seen[ST_WIDTH], status_seen[ST_OVERFLOW]);
        if (mismatches == 0)
            $display("integer_grid_text_parser verification clean");
        else
            $display("integer_grid_text_parser verification failed");
        $finish;
    end

endmodule
